/* hw/rtl/ohlc_pkg.sv */
// Shared types and constants for the OHLC candle builder.
// Payload structs, controller/datapath command and status, divider sizing.
// No dependencies.
package ohlc_pkg;

  // Serial divider sizing: 64-bit dividend, 48-bit divisor, low 32 quotient bits
  localparam int DVD_W = 64;
  localparam int DVS_W = 48;
  localparam int Q_W   = 32;

  localparam int PERIOD_W = 48;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 48'd1000;

  // Divider operand select
  localparam logic [1:0] SEL_BUY  = 2'd0;
  localparam logic [1:0] SEL_SELL = 2'd1;
  localparam logic [1:0] SEL_MOD  = 2'd2;

  // Input action codes
  localparam logic ACT_TRADE = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic        action;
    logic [63:0] trade_time;
    logic        trade_side;
    logic [31:0] trade_price;
    logic [31:0] trade_amount;
  } ohlc_in_t;

  typedef struct packed {
    logic [63:0] candle_start;
    logic [31:0] first_px;
    logic [31:0] peak_px;
    logic [31:0] floor_px;
    logic [31:0] last_px;
    logic [31:0] buy_avg_px;
    logic [31:0] sell_avg_px;
    logic [47:0] buy_volume;
    logic [47:0] sell_volume;
    logic [31:0] buy_trades;
    logic [31:0] sell_trades;
  } ohlc_out_t;

  // Controller to datapath
  typedef struct packed {
    logic       add_now;    // fold the port trade into the open candle
    logic       capture;    // hold the accepted item for a deferred close
    logic       div_start;
    logic [1:0] div_sel;
    logic       save_buy;
    logic       save_sell;
    logic       save_mod;
    logic       load_out;   // emit candle, then clear or restart
  } ohlc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_flush;   // port item is a flush
    logic in_closes;  // port trade lies past the open window
    logic active;
    logic cap_flush;  // held item is a flush
    logic div_done;
  } ohlc_sts_t;

endpackage

/* hw/rtl/ohlc_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Gives the remainder and the low quotient bits. Uses ohlc_pkg.
module ohlc_div import ohlc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quot,
  output logic [DVS_W-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   sh;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_next;

  // One shift-and-subtract step
  always_comb begin
    sh       = {rem, dvd[DVD_W-1]};
    diff     = sh - {1'b0, dvs};
    ge       = (sh >= {1'b0, dvs});
    rem_next = ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
  end

  // Step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DVD_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (cnt != '0) begin
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      rem  <= rem_next;
      quot <= {quot[Q_W-2:0], ge};
    end
  end

endmodule

/* hw/rtl/ohlc_dp.sv */
// Candle datapath: period register, candle accumulators, held item,
// output register and the shared serial divider. Uses ohlc_pkg, ohlc_div.
module ohlc_dp import ohlc_pkg::*; #(
  parameter int PRICE_WIDTH = 32,
  parameter int TIME_WIDTH  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  ohlc_in_t            in_data,
  input  ohlc_cmd_t           cmd,
  output ohlc_sts_t           sts,
  output ohlc_out_t           out_data
);

  localparam int PW = (PRICE_WIDTH < 32) ? PRICE_WIDTH : 32;
  localparam int TW = TIME_WIDTH;
  localparam int CW = (TW > PERIOD_W) ? TW : PERIOD_W;

  // Configuration
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] per_eff;

  // Candle state
  logic          active;
  logic [TW-1:0] ws;
  logic [PW-1:0] first_p, max_p, min_p, last_p;
  logic [63:0]   buy_sum, sell_sum;
  logic [47:0]   buy_qty, sell_qty;
  logic [31:0]   buy_cnt, sell_cnt;

  // Held item and division results
  logic          cap_flush;
  logic [TW-1:0] cap_time;
  logic          cap_side;
  logic [PW-1:0] cap_price;
  logic [31:0]   cap_amount;
  logic [31:0]   avg_buy, avg_sell;
  logic [DVS_W-1:0] mod_rem;

  // Divider hookup
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [Q_W-1:0]   div_quot;
  logic [DVS_W-1:0] div_rem;

  // Port item fields, low bits in use
  logic [TW-1:0] in_time;
  logic [PW-1:0] in_price;
  logic [TW-1:0] in_delta;
  logic          closes;

  // Trade update operands and results
  logic          fresh;
  logic          t_side;
  logic [PW-1:0] t_price;
  logic [31:0]   t_amount;
  logic [TW-1:0] dm1;
  logic [TW-1:0] new_ws;
  logic [PW-1:0] b_max, b_min;
  logic [63:0]   b_bsum, b_ssum;
  logic [47:0]   b_bqty, b_sqty;
  logic [31:0]   b_bcnt, b_scnt;
  logic [PW-1:0] max_next, min_next;
  logic [63:0]   bsum_next, ssum_next;
  logic [47:0]   bqty_next, sqty_next;
  logic [31:0]   bcnt_next, scnt_next;
  logic [64:0]   psum;
  logic [48:0]   qsum;

  assign per_eff  = (period == '0) ? PERIOD_W'(1) : period;
  assign in_time  = in_data.trade_time[TW-1:0];
  assign in_price = in_data.trade_price[PW-1:0];
  assign in_delta = in_time - ws;
  assign closes   = active && (in_time > ws) && (CW'(in_delta) > CW'(per_eff));

  // Status to controller
  always_comb begin
    sts.in_flush  = (in_data.action == ACT_FLUSH);
    sts.in_closes = closes;
    sts.active    = active;
    sts.cap_flush = cap_flush;
    sts.div_done  = div_done;
  end

  // Divider operand select
  assign dm1 = cap_time - ws - TW'(1);
  always_comb begin
    unique case (cmd.div_sel)
      SEL_BUY: begin
        div_dvd = buy_sum;
        div_dvs = DVS_W'(buy_cnt);
      end
      SEL_SELL: begin
        div_dvd = sell_sum;
        div_dvs = DVS_W'(sell_cnt);
      end
      SEL_MOD: begin
        div_dvd = DVD_W'(dm1);
        div_dvs = DVS_W'(per_eff);
      end
      default: begin
        div_dvd = '0;
        div_dvs = '0;
      end
    endcase
  end

  ohlc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // New window start: latest boundary strictly before the held trade
  assign new_ws = cap_time - TW'(1) - TW'(mod_rem);

  // Trade source: port in idle, held item on restart after an emit
  always_comb begin
    fresh    = !active || cmd.load_out;
    t_side   = cmd.load_out ? cap_side   : in_data.trade_side;
    t_price  = cmd.load_out ? cap_price  : in_price;
    t_amount = cmd.load_out ? cap_amount : in_data.trade_amount;
    b_max    = fresh ? t_price : max_p;
    b_min    = fresh ? t_price : min_p;
    b_bsum   = fresh ? '0 : buy_sum;
    b_ssum   = fresh ? '0 : sell_sum;
    b_bqty   = fresh ? '0 : buy_qty;
    b_sqty   = fresh ? '0 : sell_qty;
    b_bcnt   = fresh ? '0 : buy_cnt;
    b_scnt   = fresh ? '0 : sell_cnt;
  end

  // Saturating side update
  always_comb begin
    max_next  = (t_price > b_max) ? t_price : b_max;
    min_next  = (t_price < b_min) ? t_price : b_min;
    bsum_next = b_bsum;
    ssum_next = b_ssum;
    bqty_next = b_bqty;
    sqty_next = b_sqty;
    bcnt_next = b_bcnt;
    scnt_next = b_scnt;
    psum = 65'(t_side ? b_bsum : b_ssum) + 65'(t_price);
    qsum = 49'(t_side ? b_bqty : b_sqty) + 49'(t_amount);
    if (t_side) begin
      if (b_bcnt != '1) begin
        bcnt_next = b_bcnt + 32'd1;
        bsum_next = psum[64] ? '1 : psum[63:0];
      end
      bqty_next = qsum[48] ? '1 : qsum[47:0];
    end else begin
      if (b_scnt != '1) begin
        scnt_next = b_scnt + 32'd1;
        ssum_next = psum[64] ? '1 : psum[63:0];
      end
      sqty_next = qsum[48] ? '1 : qsum[47:0];
    end
  end

  // Control registers: period and candle open flag
  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
      active <= 1'b0;
    end else begin
      if (cfg_valid) begin
        period <= cfg_data;
      end
      if (cmd.add_now) begin
        active <= 1'b1;
      end else if (cmd.load_out) begin
        active <= !cap_flush;
      end
    end
  end

  // Candle accumulators
  always_ff @(posedge clk) begin
    if (cmd.add_now || (cmd.load_out && !cap_flush)) begin
      if (cmd.load_out) begin
        ws <= new_ws;
      end else if (!active) begin
        ws <= in_time;
      end
      if (fresh) begin
        first_p <= t_price;
      end
      max_p    <= max_next;
      min_p    <= min_next;
      last_p   <= t_price;
      buy_sum  <= bsum_next;
      sell_sum <= ssum_next;
      buy_qty  <= bqty_next;
      sell_qty <= sqty_next;
      buy_cnt  <= bcnt_next;
      sell_cnt <= scnt_next;
    end
  end

  // Held item and division results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_flush  <= (in_data.action == ACT_FLUSH);
      cap_time   <= in_time;
      cap_side   <= in_data.trade_side;
      cap_price  <= in_price;
      cap_amount <= in_data.trade_amount;
    end
    if (cmd.save_buy) begin
      avg_buy <= (buy_cnt == '0) ? '0 : 32'(div_quot);
    end
    if (cmd.save_sell) begin
      avg_sell <= (sell_cnt == '0) ? '0 : 32'(div_quot);
    end
    if (cmd.save_mod) begin
      mod_rem <= div_rem;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.candle_start <= 64'(ws);
      out_data.first_px     <= 32'(first_p);
      out_data.peak_px      <= 32'(max_p);
      out_data.floor_px     <= 32'(min_p);
      out_data.last_px      <= 32'(last_p);
      out_data.buy_avg_px   <= avg_buy;
      out_data.sell_avg_px  <= avg_sell;
      out_data.buy_volume   <= buy_qty;
      out_data.sell_volume  <= sell_qty;
      out_data.buy_trades   <= buy_cnt;
      out_data.sell_trades  <= sell_cnt;
    end
  end

endmodule

/* hw/rtl/ohlc_ctrl.sv */
// Candle controller: sequences the close of a candle through the divider
// and the output register. Uses ohlc_pkg.
module ohlc_ctrl import ohlc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_stall,
  input  ohlc_sts_t sts,
  output ohlc_cmd_t cmd,
  output logic      in_stall,
  output logic      out_valid
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BUY  = 3'd1;
  localparam logic [2:0] S_SELL = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = SEL_BUY;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.in_flush) begin
            if (sts.active) begin
              cmd.capture   = 1'b1;
              cmd.div_start = 1'b1;
              state_next    = S_BUY;
            end
          end else if (sts.in_closes) begin
            cmd.capture   = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = S_BUY;
          end else begin
            cmd.add_now = 1'b1;
          end
        end
      end
      S_BUY: begin
        if (sts.div_done) begin
          cmd.save_buy  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_SELL;
          state_next    = S_SELL;
        end
      end
      S_SELL: begin
        cmd.div_sel = SEL_MOD;
        if (sts.div_done) begin
          cmd.save_sell = 1'b1;
          if (sts.cap_flush) begin
            state_next = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.div_sel = SEL_MOD;
        if (sts.div_done) begin
          cmd.save_mod = 1'b1;
          state_next   = S_OUT;
        end
      end
      S_OUT: begin
        cmd.div_sel = SEL_MOD;
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/ohlc_candle_builder.sv */
// Top level of the OHLC candle builder: controller plus datapath.
// Uses ohlc_pkg, ohlc_ctrl, ohlc_dp (which holds ohlc_div).
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  ohlc_in_t  in_data
//   out      output     out_valid/ out_stall ohlc_out_t out_data
//   cfg      input      cfg_valid/ cfg_ready 48-bit candle period
//
// A trade inside the open window or a flush with no open candle is taken without stalling the input.
// A flush of an open candle, or a trade that closes a candle, stalls the input while
// the one shared bit-serial divider forms the buy average, sell average and (trade
// only) window realignment, each in 64 shift-and-subtract steps, and then the output
// register is loaded, which waits while an earlier result is still stalled.
// Reset is synchronous; it sets the period to 1000 and closes any candle.
// A stalled result holds in the output register; the next item is taken meanwhile
// and only waits if it closes another candle before the first is transferred.
module ohlc_candle_builder import ohlc_pkg::*; #(
  parameter int PRICE_WIDTH = 32,
  parameter int TIME_WIDTH  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ohlc_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ohlc_out_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  ohlc_cmd_t cmd;
  ohlc_sts_t sts;

  // Period writes are taken at any time
  assign cfg_ready = 1'b1;

  ohlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  ohlc_dp #(
    .PRICE_WIDTH (PRICE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
